>>> rtl/pdr_pkg.sv
// Shared constants, types and the sigmoid table of the perceptron trainer.
`timescale 1ns / 1ps

package pdr_pkg;

    // Sizing
    localparam int PATTERN_COUNT       = 4;
    localparam int FRACTION_BITS       = 12;
    localparam int SIGMOID_TABLE_DEPTH = 256;

    localparam int PIDX_W    = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
    localparam int SIG_IDX_W = $clog2(SIGMOID_TABLE_DEPTH);

    // Field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 2;
    localparam int FEAT_W  = 5;
    localparam int NET_W   = 16;
    localparam int ACT_W   = 13;
    localparam int ERR_W   = 14;
    localparam int WGT_W   = 16;
    localparam int EPOCH_W = 7;
    localparam int LR_W    = 13;
    localparam int CFG_W   = 14;

    localparam int CFG_IDX_W = 3;
    localparam int ACT_ONE   = 4096;

    // Datapath widths
    localparam int NETP_W    = WGT_W + FEAT_W;
    localparam int NET_SUM_W = NETP_W + 2;
    localparam int ACC_W     = ERR_W + FEAT_W + $clog2(PATTERN_COUNT);
    localparam int ESUM_W    = ERR_W + $clog2(PATTERN_COUNT);
    localparam int MUL_A_W   = (ACC_W > WGT_W) ? ACC_W : WGT_W;
    localparam int MUL_B_W   = LR_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int UPD_W     = MUL_P_W + 2;
    localparam int UPD_SHIFT = 24 - FRACTION_BITS;
    localparam int UPD_HALF  = 1 << (UPD_SHIFT - 1);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_TRAIN = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 3'd0,
        CFG_MAX_EPOCHS    = 3'd1,
        CFG_INIT_WEIGHT_A = 3'd2,
        CFG_INIT_WEIGHT_B = 3'd3,
        CFG_BIAS_VALUE    = 3'd4
    } cfg_idx_t;

    // One stored pattern
    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_a;
        logic signed [FEAT_W-1:0] feature_b;
        logic                     target;
    } pat_entry_t;

    // Pattern table write request
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [PIDX_W-1:0] addr;
        pat_entry_t        data;
    } pat_wr_t;

    // Per-pattern result of the latest epoch
    typedef struct packed {
        logic signed [NET_W-1:0] net;
        logic        [ACT_W-1:0] act;
        logic signed [ERR_W-1:0] err;
    } res_entry_t;

    typedef logic [ACT_W-1:0] sig_lut_t [SIGMOID_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Restoring long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-f in Q30 for f in [0, 1], Taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        longint      sum;
        logic [63:0] term;
        logic [63:0] prod;
        sum  = longint'(Q30_ONE);
        term = Q30_ONE;
        for (int k = 1; k <= 24; k++) begin
            prod = term * f;
            term = udiv64(prod >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    // Sigmoid of a bin center, Q1.12
    function automatic logic [ACT_W-1:0] sigmoid_entry(input longint c,
                                                       input logic [63:0] em1);
        logic [63:0] mag;
        logic [63:0] x30;
        logic [63:0] d;
        logic [63:0] den;
        logic [63:0] sp;
        logic [63:0] whole;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        if (mag > (64'd16 << FRACTION_BITS)) begin
            mag = 64'd16 << FRACTION_BITS;
        end
        x30   = mag << (30 - FRACTION_BITS);
        whole = x30 >> 30;
        d     = exp_neg_q30(x30 & (Q30_ONE - 64'd1));
        for (int i = 0; i < 17; i++) begin
            if (64'(i) < whole) begin
                d = (d * em1) >> 30;
            end
        end
        den = Q30_ONE + d;
        sp  = udiv64((64'(ACT_ONE) << 30) + (den >> 1), den);
        if (c < 0) begin
            sp = 64'(ACT_ONE) - sp;
        end
        return ACT_W'(sp);
    endfunction

    function automatic sig_lut_t build_sig_lut();
        sig_lut_t    lut;
        logic [63:0] em1;
        longint      c;
        em1 = exp_neg_q30(Q30_ONE);
        for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
            c = -32768 + ((2 * longint'(k) + 1) * 32768) / SIGMOID_TABLE_DEPTH;
            lut[k] = sigmoid_entry(c, em1);
        end
        return lut;
    endfunction

    localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage

>>> rtl/pdr_pattern_store.sv
// Pattern table: synchronous memory with per-entry valid bits for fast clear.
`timescale 1ns / 1ps

module pdr_pattern_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pdr_pkg::pat_wr_t           wr,
    input  logic                       rd_en,
    input  logic [pdr_pkg::PIDX_W-1:0] rd_addr,
    output pdr_pkg::pat_entry_t        rd_data
);
    import pdr_pkg::*;

    pat_entry_t               pat_mem_reg [PATTERN_COUNT];
    logic [PATTERN_COUNT-1:0] valid_reg;
    pat_entry_t               rd_data_reg;
    logic                     rd_valid_reg;

    // Memory array write and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            pat_mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= pat_mem_reg[rd_addr];
        end
    end

    // Valid bits: an entry never written since reset or clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.clear) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/pdr_result_store.sv
// Result memory: net, activation and error of each pattern in the latest epoch.
`timescale 1ns / 1ps

module pdr_result_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [pdr_pkg::PIDX_W-1:0] wr_addr,
    input  pdr_pkg::res_entry_t        wr_data,
    input  logic                       rd_en,
    input  logic [pdr_pkg::PIDX_W-1:0] rd_addr,
    output pdr_pkg::res_entry_t        rd_data
);
    import pdr_pkg::*;

    res_entry_t res_mem_reg [PATTERN_COUNT];
    res_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            res_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= res_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pdr_mult.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module pdr_mult (
    input  logic                               aclk,
    input  logic signed [pdr_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [pdr_pkg::MUL_B_W-1:0] op_b,
    output logic signed [pdr_pkg::MUL_P_W-1:0] prod
);
    import pdr_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/perceptron_delta_rule_trainer.sv
// Two-input sigmoid perceptron trainer: control sequencer and datapath.
// Write and clear items are handled in S_IDLE, which the block does not leave for them.
// A train item runs S_RD, S_MA, S_MB, S_NET, S_ACT, S_EA, S_EB and S_EC for each pattern,
// then S_UA, S_UB and S_UC for the weight update, up to max_epochs epochs, all on one multiplier.
// Each result is read in S_RR and loaded into the output register in S_RO once it is free.
// Reset restores register defaults, empties the pattern table and drops m_valid.
`timescale 1ns / 1ps

module perceptron_delta_rule_trainer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [pdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdr_pkg::CFG_W-1:0]           cfg_wdata,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pdr_pkg::OP_W-1:0]            s_op,
    input  logic [pdr_pkg::SLOT_W-1:0]          s_pattern_slot,
    input  logic signed [pdr_pkg::FEAT_W-1:0]   s_feature_a,
    input  logic signed [pdr_pkg::FEAT_W-1:0]   s_feature_b,
    input  logic                                s_target_value,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdr_pkg::SLOT_W-1:0]          m_report_slot,
    output logic signed [pdr_pkg::NET_W-1:0]    m_net_sum,
    output logic [pdr_pkg::ACT_W-1:0]           m_activation,
    output logic signed [pdr_pkg::ERR_W-1:0]    m_pattern_error,
    output logic [pdr_pkg::EPOCH_W-1:0]         m_epochs_run,
    output logic                                m_last_report
);
    import pdr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MA, S_MB, S_NET, S_ACT, S_EA, S_EB, S_EC,
        S_UA, S_UB, S_UC, S_RR, S_RO
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic        [LR_W-1:0]    learning_rate_reg, learning_rate_next;
    logic        [EPOCH_W-1:0] max_epochs_reg, max_epochs_next;
    logic signed [CFG_W-1:0]   init_a_reg, init_a_next;
    logic signed [CFG_W-1:0]   init_b_reg, init_b_next;
    logic signed [CFG_W-1:0]   bias_reg, bias_next;

    // training state
    logic        [PIDX_W-1:0]  slot_reg, slot_next;
    logic signed [WGT_W-1:0]   weight_a_reg, weight_a_next;
    logic signed [WGT_W-1:0]   weight_b_reg, weight_b_next;
    logic        [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic signed [ACC_W-1:0]   acc_a_reg, acc_a_next;
    logic signed [ACC_W-1:0]   acc_b_reg, acc_b_next;
    logic signed [ESUM_W-1:0]  esum_reg, esum_next;
    logic signed [NETP_W-1:0]  prod_a_reg, prod_a_next;
    logic signed [NET_W-1:0]   net_reg, net_next;
    logic        [ACT_W-1:0]   act_reg, act_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic        [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic signed [NET_W-1:0]   m_net_reg, m_net_next;
    logic        [ACT_W-1:0]   m_act_reg, m_act_next;
    logic signed [ERR_W-1:0]   m_err_reg, m_err_next;
    logic        [EPOCH_W-1:0] m_epochs_reg, m_epochs_next;
    logic                      m_last_reg, m_last_next;

    // memory and multiplier hookup
    pat_wr_t                   pat_wr;
    pat_entry_t                pat_rd;
    logic                      pat_rd_en;
    res_entry_t                res_wr_data;
    res_entry_t                res_rd;
    logic                      res_wr_en;
    logic                      res_rd_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    // combinational helpers
    logic                        s_accept;
    logic                        last_slot;
    logic signed [NET_SUM_W-1:0] net_full;
    logic signed [NET_W-1:0]     net_sat;
    logic        [NET_W-1:0]     net_biased;
    logic        [SIG_IDX_W-1:0] sig_idx;
    logic        [ACT_W-1:0]     act_lookup;
    logic        [ERR_W-1:0]     target_ext;
    logic signed [ERR_W-1:0]     err_calc;
    logic signed [UPD_W-1:0]     upd_sum;
    logic signed [UPD_W-1:0]     w_sum;
    logic signed [WGT_W-1:0]     w_sel;
    logic signed [WGT_W-1:0]     w_sat;
    logic        [EPOCH_W-1:0]   epoch_inc;

    pdr_pattern_store u_pattern_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (pat_wr),
        .rd_en   (pat_rd_en),
        .rd_addr (slot_reg),
        .rd_data (pat_rd)
    );

    pdr_result_store u_result_store (
        .aclk    (aclk),
        .wr_en   (res_wr_en),
        .wr_addr (slot_reg),
        .wr_data (res_wr_data),
        .rd_en   (res_rd_en),
        .rd_addr (slot_reg),
        .rd_data (res_rd)
    );

    pdr_mult u_mult (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign last_slot = (slot_reg == PIDX_W'(PATTERN_COUNT - 1));

    // pattern table writes straight from the input item
    always_comb begin
        pat_wr.en             = s_accept && (s_op == OP_WRITE)
                                && (int'(s_pattern_slot) < PATTERN_COUNT);
        pat_wr.clear          = s_accept && (s_op == OP_CLEAR);
        pat_wr.addr           = PIDX_W'(s_pattern_slot);
        pat_wr.data.feature_a = s_feature_a;
        pat_wr.data.feature_b = s_feature_b;
        pat_wr.data.target    = s_target_value;
    end

    assign pat_rd_en = (state_reg == S_RD);
    assign res_rd_en = (state_reg == S_RR);
    assign res_wr_en = (state_reg == S_EA);
    assign res_wr_data.net = net_reg;
    assign res_wr_data.act = act_reg;
    assign res_wr_data.err = err_reg;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MA: begin
                mul_a = MUL_A_W'(weight_a_reg);
                mul_b = MUL_B_W'(pat_rd.feature_a);
            end
            S_MB: begin
                mul_a = MUL_A_W'(weight_b_reg);
                mul_b = MUL_B_W'(pat_rd.feature_b);
            end
            S_EA: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(pat_rd.feature_a);
            end
            S_EB: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(pat_rd.feature_b);
            end
            S_UA: begin
                mul_a = MUL_A_W'(acc_a_reg);
                mul_b = signed'({1'b0, learning_rate_reg});
            end
            S_UB: begin
                mul_a = MUL_A_W'(acc_b_reg);
                mul_b = signed'({1'b0, learning_rate_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // net: both products plus bias, saturated
    always_comb begin
        net_full = NET_SUM_W'(prod_a_reg) + NET_SUM_W'(mul_p) + NET_SUM_W'(bias_reg);
        if (net_full > NET_SUM_W'(32767)) begin
            net_sat = 16'sh7FFF;
        end else if (net_full < -NET_SUM_W'(32768)) begin
            net_sat = -16'sh8000;
        end else begin
            net_sat = NET_W'(net_full);
        end
    end

    // sigmoid lookup: top bits of net with the sign flipped
    assign net_biased = {~net_reg[NET_W-1], net_reg[NET_W-2:0]};
    assign sig_idx    = net_biased[NET_W-1 -: SIG_IDX_W];
    assign act_lookup = SIG_LUT[sig_idx];
    assign target_ext = pat_rd.target ? ERR_W'(ACT_ONE) : '0;
    assign err_calc   = signed'(target_ext - {1'b0, act_lookup});

    // weight step: round half up, then saturate the new weight
    always_comb begin
        w_sel   = (state_reg == S_UB) ? weight_a_reg : weight_b_reg;
        upd_sum = UPD_W'(mul_p) + UPD_W'(UPD_HALF);
        w_sum   = UPD_W'(w_sel) + (upd_sum >>> UPD_SHIFT);
        if (w_sum > UPD_W'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -UPD_W'(32768)) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = WGT_W'(w_sum);
        end
    end

    assign epoch_inc = epoch_reg + EPOCH_W'(1);

    // sequencer and register updates
    always_comb begin
        state_next         = state_reg;
        learning_rate_next = learning_rate_reg;
        max_epochs_next    = max_epochs_reg;
        init_a_next        = init_a_reg;
        init_b_next        = init_b_reg;
        bias_next          = bias_reg;
        slot_next          = slot_reg;
        weight_a_next      = weight_a_reg;
        weight_b_next      = weight_b_reg;
        epoch_next         = epoch_reg;
        acc_a_next         = acc_a_reg;
        acc_b_next         = acc_b_reg;
        esum_next          = esum_reg;
        prod_a_next        = prod_a_reg;
        net_next           = net_reg;
        act_next           = act_reg;
        err_next           = err_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_slot_next        = m_slot_reg;
        m_net_next         = m_net_reg;
        m_act_next         = m_act_reg;
        m_err_next         = m_err_reg;
        m_epochs_next      = m_epochs_reg;
        m_last_next        = m_last_reg;

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEARNING_RATE: learning_rate_next = cfg_wdata[LR_W-1:0];
                CFG_MAX_EPOCHS:    max_epochs_next    = cfg_wdata[EPOCH_W-1:0];
                CFG_INIT_WEIGHT_A: init_a_next        = signed'(cfg_wdata);
                CFG_INIT_WEIGHT_B: init_b_next        = signed'(cfg_wdata);
                CFG_BIAS_VALUE:    bias_next          = signed'(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_op == OP_TRAIN)) begin
                    weight_a_next = WGT_W'(init_a_reg);
                    weight_b_next = WGT_W'(init_b_reg);
                    epoch_next    = '0;
                    acc_a_next    = '0;
                    acc_b_next    = '0;
                    esum_next     = '0;
                    slot_next     = '0;
                    state_next    = S_RD;
                end
            end
            S_RD:  state_next = S_MA;
            S_MA:  state_next = S_MB;
            S_MB: begin
                prod_a_next = NETP_W'(mul_p);
                state_next  = S_NET;
            end
            S_NET: begin
                net_next   = net_sat;
                state_next = S_ACT;
            end
            S_ACT: begin
                act_next   = act_lookup;
                err_next   = err_calc;
                state_next = S_EA;
            end
            S_EA: begin
                esum_next  = esum_reg + ESUM_W'(err_reg);
                state_next = S_EB;
            end
            S_EB: begin
                acc_a_next = acc_a_reg + ACC_W'(mul_p);
                state_next = S_EC;
            end
            S_EC: begin
                acc_b_next = acc_b_reg + ACC_W'(mul_p);
                if (last_slot) begin
                    state_next = S_UA;
                end else begin
                    slot_next  = slot_reg + PIDX_W'(1);
                    state_next = S_RD;
                end
            end
            S_UA:  state_next = S_UB;
            S_UB: begin
                weight_a_next = w_sat;
                state_next    = S_UC;
            end
            S_UC: begin
                weight_b_next = w_sat;
                epoch_next    = epoch_inc;
                slot_next     = '0;
                if ((esum_reg == '0) || (epoch_inc >= max_epochs_reg)) begin
                    state_next = S_RR;
                end else begin
                    acc_a_next = '0;
                    acc_b_next = '0;
                    esum_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RR:  state_next = S_RO;
            S_RO: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = SLOT_W'(slot_reg);
                    m_net_next    = res_rd.net;
                    m_act_next    = res_rd.act;
                    m_err_next    = res_rd.err;
                    m_epochs_next = epoch_reg;
                    m_last_next   = last_slot;
                    if (last_slot) begin
                        state_next = S_IDLE;
                    end else begin
                        slot_next  = slot_reg + PIDX_W'(1);
                        state_next = S_RR;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            learning_rate_reg <= LR_W'(2048);
            max_epochs_reg    <= EPOCH_W'(100);
            init_a_reg        <= '0;
            init_b_reg        <= '0;
            bias_reg          <= '0;
        end else begin
            state_reg         <= state_next;
            m_valid_reg       <= m_valid_next;
            learning_rate_reg <= learning_rate_next;
            max_epochs_reg    <= max_epochs_next;
            init_a_reg        <= init_a_next;
            init_b_reg        <= init_b_next;
            bias_reg          <= bias_next;
            slot_reg          <= slot_next;
            weight_a_reg      <= weight_a_next;
            weight_b_reg      <= weight_b_next;
            epoch_reg         <= epoch_next;
            acc_a_reg         <= acc_a_next;
            acc_b_reg         <= acc_b_next;
            esum_reg          <= esum_next;
            prod_a_reg        <= prod_a_next;
            net_reg           <= net_next;
            act_reg           <= act_next;
            err_reg           <= err_next;
            m_slot_reg        <= m_slot_next;
            m_net_reg         <= m_net_next;
            m_act_reg         <= m_act_next;
            m_err_reg         <= m_err_next;
            m_epochs_reg      <= m_epochs_next;
            m_last_reg        <= m_last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_report_slot   = m_slot_reg;
    assign m_net_sum       = m_net_reg;
    assign m_activation    = m_act_reg;
    assign m_pattern_error = m_err_reg;
    assign m_epochs_run    = m_epochs_reg;
    assign m_last_report   = m_last_reg;

endmodule

>>> rtl/pdr_checker.sv
// Port-level checks of the perceptron trainer and their bind to the top level.
`timescale 1ns / 1ps

module pdr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [pdr_pkg::SLOT_W-1:0]        m_report_slot,
    input logic signed [pdr_pkg::NET_W-1:0]  m_net_sum,
    input logic [pdr_pkg::ACT_W-1:0]         m_activation,
    input logic signed [pdr_pkg::ERR_W-1:0]  m_pattern_error,
    input logic [pdr_pkg::EPOCH_W-1:0]       m_epochs_run,
    input logic                              m_last_report
);
    import pdr_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled item holds its slot, net, activation and error
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_net_sum) && $stable(m_report_slot)
            && $stable(m_activation) && $stable(m_pattern_error))
        else $error("stalled result changed");

    // the final item of a run describes the last table entry
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_report |-> m_report_slot == SLOT_W'(PATTERN_COUNT - 1))
        else $error("last report on wrong slot");

    // error is target minus activation with a 0/1 target
    a_err_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pattern_error + signed'({1'b0, m_activation}) == 14'sd0)
                 || (m_pattern_error + signed'({1'b0, m_activation}) == 14'sd4096))
        else $error("pattern error does not match activation");

    // every run performs at least one epoch
    a_epochs_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_epochs_run != '0)
        else $error("zero epochs reported");

endmodule

bind perceptron_delta_rule_trainer pdr_checker u_pdr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_report_slot   (m_report_slot),
    .m_net_sum       (m_net_sum),
    .m_activation    (m_activation),
    .m_pattern_error (m_pattern_error),
    .m_epochs_run    (m_epochs_run),
    .m_last_report   (m_last_report)
);
